// ===== rtl/twcc_pkg.sv =====
// shared types and constants for the tree weighted center cost block
package twcc_pkg;

  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned CHILD_W  = 8;
  localparam int unsigned TOTAL_W  = 32;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // control that travels with one distance/weight read through the cost pipeline
  typedef struct packed {
    logic vld;
    logic row_first;
    logic row_last;
    logic first_row;
    logic last_row;
  } acc_ctl_t;

endpackage

// ===== rtl/twcc_dist_ram.sv =====
// distance matrix memory: one write port, two registered read ports
module twcc_dist_ram #(
  parameter int unsigned ADDR_W = 14,
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] ra_addr_i,
  input  logic [ADDR_W-1:0] rb_addr_i,
  output logic [DATA_W-1:0] ra_data_o,
  output logic [DATA_W-1:0] rb_data_o
);

  logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
  logic [DATA_W-1:0] ra_q;
  logic [DATA_W-1:0] rb_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    ra_q <= mem[ra_addr_i];
    rb_q <= mem[rb_addr_i];
  end

  assign ra_data_o = ra_q;
  assign rb_data_o = rb_q;

endmodule

// ===== rtl/twcc_cost_acc.sv =====
// weight memory and weighted distance sum pipeline with running minimum
module twcc_cost_acc
  import twcc_pkg::*;
#(
  parameter int unsigned MAX_NODES = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        w_we_i,
  input  logic [$clog2(MAX_NODES)-1:0] w_waddr_i,
  input  logic [WEIGHT_W-1:0]         w_wdata_i,
  input  logic [$clog2(MAX_NODES)-1:0] w_raddr_i,
  input  logic [$clog2(MAX_NODES):0]  dist_i,
  input  acc_ctl_t                    ctl_i,
  output logic [TOTAL_W-1:0]          best_o,
  output logic                        done_o
);

  localparam int unsigned DIST_W = $clog2(MAX_NODES) + 1;
  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

  logic [WEIGHT_W-1:0] wmem [0:MAX_NODES-1];
  logic [WEIGHT_W-1:0] wrd_q;
  acc_ctl_t            ctl1_q;
  acc_ctl_t            ctl2_q;
  logic [TOTAL_W-1:0]  term2_q;
  logic [TOTAL_W-1:0]  acc_q;
  logic [TOTAL_W-1:0]  best_q;
  logic                done_q;

  logic                         inf1;
  logic [DIST_W+WEIGHT_W-1:0]   prod1;
  logic [TOTAL_W-1:0]           base;
  logic [TOTAL_W:0]             sum;
  logic [TOTAL_W-1:0]           acc_d;

  always_ff @(posedge clk_i) begin
    if (w_we_i) begin
      wmem[w_waddr_i] <= w_wdata_i;
    end
    wrd_q <= wmem[w_raddr_i];
  end

  // unreachable node with nonzero weight pins the sum at max
  assign inf1  = (dist_i == DIST_INF) && (wrd_q != '0);
  assign prod1 = dist_i * wrd_q;

  assign base  = ctl2_q.row_first ? '0 : acc_q;
  assign sum   = {1'b0, base} + {1'b0, term2_q};
  assign acc_d = (sum >= {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q  <= '0;
      ctl2_q  <= '0;
      term2_q <= '0;
      acc_q   <= '0;
      best_q  <= TOTAL_MAX;
      done_q  <= 1'b0;
    end else begin
      ctl1_q  <= ctl_i;
      ctl2_q  <= ctl1_q;
      term2_q <= inf1 ? TOTAL_MAX : TOTAL_W'(prod1);
      done_q  <= ctl2_q.vld && ctl2_q.row_last && ctl2_q.last_row;
      if (ctl2_q.vld) begin
        acc_q <= acc_d;
        if (ctl2_q.row_last && (ctl2_q.first_row || (acc_d < best_q))) begin
          best_q <= acc_d;
        end
      end
    end
  end

  assign best_o = best_q;
  assign done_o = done_q;

endmodule

// ===== rtl/twcc_seq.sv =====
// sequencer: node loading, matrix clearing, floyd passes and sum scan
module twcc_seq
  import twcc_pkg::*;
#(
  parameter int unsigned MAX_NODES = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [WEIGHT_W-1:0]            weight_i,
  input  logic [CHILD_W-1:0]             left_i,
  input  logic [CHILD_W-1:0]             right_i,
  input  logic                           last_i,
  input  logic                           out_busy_i,
  output logic                           res_valid_o,
  output logic                           d_we_o,
  output logic [2*$clog2(MAX_NODES)-1:0] d_waddr_o,
  output logic [$clog2(MAX_NODES):0]     d_wdata_o,
  output logic [2*$clog2(MAX_NODES)-1:0] d_ra_addr_o,
  output logic [2*$clog2(MAX_NODES)-1:0] d_rb_addr_o,
  input  logic [$clog2(MAX_NODES):0]     d_ra_data_i,
  input  logic [$clog2(MAX_NODES):0]     d_rb_data_i,
  output logic                           w_we_o,
  output logic [$clog2(MAX_NODES)-1:0]   w_waddr_o,
  output logic [WEIGHT_W-1:0]            w_wdata_o,
  output logic [$clog2(MAX_NODES)-1:0]   w_raddr_o,
  output acc_ctl_t                       ctl_o,
  input  logic                           acc_done_i
);

  localparam int unsigned NW     = $clog2(MAX_NODES);
  localparam int unsigned CW     = $clog2(MAX_NODES + 1);
  localparam int unsigned DIST_W = NW + 1;
  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
  localparam logic [NW-1:0]     LAST_IDX = NW'(MAX_NODES - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_LINK,
    ST_FW_RIK,
    ST_FW_WIK,
    ST_FW_ROW,
    ST_SUM,
    ST_SUM_WAIT,
    ST_DONE
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   cnt_q;
  logic [NW-1:0]   last_q;
  logic [NW-1:0]   i_q;
  logic [NW-1:0]   j_q;
  logic [NW-1:0]   k_q;
  logic [3:0]      mask_q;
  logic [NW-1:0]   self_q;
  logic [NW-1:0]   lidx_q;
  logic [NW-1:0]   ridx_q;
  logic            run_q;
  logic [DIST_W-1:0] ik_q;
  logic            p1_vld_q;
  logic [NW-1:0]   p1_i_q;
  logic [NW-1:0]   p1_j_q;
  logic            res_valid_q;

  logic            accept;
  logic            room;
  logic            done_go;
  logic [NW-1:0]   self;
  logic [31:0]     lsub;
  logic [31:0]     rsub;
  logic [NW-1:0]   lidx;
  logic [NW-1:0]   ridx;
  logic            l_ok;
  logic            r_ok;
  logic [3:0]      mask_new;
  logic [3:0]      mask_rest;
  logic [CW-1:0]   cnt_d;
  logic [CW-1:0]   cnt_m1;
  logic [DIST_W:0] via;
  logic            fw_wr;

  assign accept  = in_valid_i && (state_q == ST_LOAD);
  assign room    = cnt_q < CW'(MAX_NODES);
  // result handed to the output register, tree state starts over
  assign done_go = (state_q == ST_DONE) && !out_busy_i;
  assign self    = cnt_q[NW-1:0];
  assign lsub    = 32'(left_i) - 32'd1;
  assign rsub    = 32'(right_i) - 32'd1;
  assign lidx    = lsub[NW-1:0];
  assign ridx    = rsub[NW-1:0];
  // child 0, child past the end and self links add no edge
  assign l_ok   = room && (left_i != '0) && (32'(left_i) <= 32'(MAX_NODES)) && (lidx != self);
  assign r_ok   = room && (right_i != '0) && (32'(right_i) <= 32'(MAX_NODES)) && (ridx != self);
  assign mask_new  = {r_ok, r_ok, l_ok, l_ok};
  assign mask_rest = mask_q & (mask_q - 4'd1);
  assign cnt_d     = done_go ? '0 : (accept && room) ? cnt_q + CW'(1) : cnt_q;
  assign cnt_m1    = cnt_d - CW'(1);

  // relaxation of d[i][j] through k, data read in the previous cycle
  assign via   = {1'b0, ik_q} + {1'b0, d_ra_data_i};
  assign fw_wr = p1_vld_q && (d_ra_data_i != DIST_INF) && (via < {1'b0, DIST_INF})
                 && (via < {1'b0, d_rb_data_i});

  assign in_ready_o = (state_q == ST_LOAD);
  assign w_we_o     = accept && room;
  assign w_waddr_o  = self;
  assign w_wdata_o  = weight_i;
  assign w_raddr_o  = j_q;

  always_comb begin
    d_we_o    = fw_wr;
    d_waddr_o = {p1_i_q, p1_j_q};
    d_wdata_o = via[DIST_W-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        d_we_o    = 1'b1;
        d_waddr_o = {i_q, j_q};
        d_wdata_o = (i_q == j_q) ? '0 : DIST_INF;
      end
      ST_LINK: begin
        d_we_o    = 1'b1;
        d_wdata_o = DIST_W'(1);
        priority if (mask_q[0]) d_waddr_o = {self_q, lidx_q};
        else if (mask_q[1])     d_waddr_o = {lidx_q, self_q};
        else if (mask_q[2])     d_waddr_o = {self_q, ridx_q};
        else                    d_waddr_o = {ridx_q, self_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    d_ra_addr_o = {i_q, j_q};
    d_rb_addr_o = {i_q, j_q};
    ctl_o       = '0;
    unique case (state_q)
      ST_FW_RIK: d_ra_addr_o = {i_q, k_q};
      ST_FW_ROW: d_ra_addr_o = {k_q, j_q};
      ST_SUM: begin
        ctl_o.vld       = 1'b1;
        ctl_o.row_first = (j_q == '0);
        ctl_o.row_last  = (j_q == last_q);
        ctl_o.first_row = (i_q == '0);
        ctl_o.last_row  = (i_q == last_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      last_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      mask_q      <= '0;
      self_q      <= '0;
      lidx_q      <= '0;
      ridx_q      <= '0;
      run_q       <= 1'b0;
      ik_q        <= '0;
      p1_vld_q    <= 1'b0;
      p1_i_q      <= '0;
      p1_j_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      p1_vld_q    <= (state_q == ST_FW_ROW);
      p1_i_q      <= i_q;
      p1_j_q      <= j_q;
      res_valid_q <= done_go;
      cnt_q       <= cnt_d;
      if (state_q == ST_LOAD || state_q == ST_LINK) begin
        last_q <= cnt_m1[NW-1:0];
        i_q    <= '0;
        k_q    <= '0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (j_q == LAST_IDX) begin
            j_q <= '0;
            if (i_q == LAST_IDX) begin
              i_q     <= '0;
              state_q <= ST_LOAD;
            end else begin
              i_q <= i_q + NW'(1);
            end
          end else begin
            j_q <= j_q + NW'(1);
          end
        end
        ST_LOAD: begin
          if (accept) begin
            mask_q <= mask_new;
            self_q <= self;
            lidx_q <= lidx;
            ridx_q <= ridx;
            run_q  <= last_i;
            if (mask_new != '0) begin
              state_q <= ST_LINK;
            end else if (last_i) begin
              state_q <= ST_FW_RIK;
            end
          end
        end
        ST_LINK: begin
          mask_q <= mask_rest;
          if (mask_rest == '0) begin
            state_q <= run_q ? ST_FW_RIK : ST_LOAD;
          end
        end
        ST_FW_RIK: state_q <= ST_FW_WIK;
        ST_FW_WIK, ST_FW_ROW: begin
          if (state_q == ST_FW_WIK && d_ra_data_i != DIST_INF) begin
            ik_q    <= d_ra_data_i;
            j_q     <= '0;
            state_q <= ST_FW_ROW;
          end else if (state_q == ST_FW_ROW && j_q != last_q) begin
            j_q <= j_q + NW'(1);
          end else begin
            // row done or skipped: next i, then next k
            j_q <= '0;
            if (i_q == last_q) begin
              i_q <= '0;
              if (k_q == last_q) begin
                state_q <= ST_SUM;
              end else begin
                k_q     <= k_q + NW'(1);
                state_q <= ST_FW_RIK;
              end
            end else begin
              i_q     <= i_q + NW'(1);
              state_q <= ST_FW_RIK;
            end
          end
        end
        ST_SUM: begin
          if (j_q == last_q) begin
            j_q <= '0;
            if (i_q == last_q) begin
              i_q     <= '0;
              state_q <= ST_SUM_WAIT;
            end else begin
              i_q <= i_q + NW'(1);
            end
          end else begin
            j_q <= j_q + NW'(1);
          end
        end
        ST_SUM_WAIT: begin
          if (acc_done_i) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (done_go) begin
            i_q     <= '0;
            j_q     <= '0;
            state_q <= ST_CLEAR;
          end
        end
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;

endmodule

// ===== rtl/tree_weighted_center_cost_top.sv =====
// top level: stream ports, sequencer, result register, distance memory and cost pipeline
//
//   channel  | dir | payload (low bit up)                                | marks
//   s_axis   | in  | node_weight[15:0] left_child[23:16] right_child[31:24] | tlast = last_node
//   m_axis   | out | min_total[31:0]                                      | none
//
// a node is taken in ST_LOAD, then ST_LINK writes the entries its child links add (up to 4)
// the run reads d[i][k] for each (k, i) pair and relaxes row i through k only where d[i][k]
// is finite, then scans all n*n weighted distances; at most one distance entry is written per cycle
// after reset and after each result the whole MAX_NODES by MAX_NODES matrix is swept
// with tready low; a result waits in the output register while the next tree loads
// a result not yet taken holds the following result back at the end of its run
module tree_weighted_center_cost_top
  import twcc_pkg::*;
#(
  parameter int unsigned MAX_NODES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // node_weight, left_child, right_child
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // min_total
);

  localparam int unsigned NW     = $clog2(MAX_NODES);
  localparam int unsigned DIST_W = NW + 1;
  localparam int unsigned ADDR_W = 2 * NW;

  logic              d_we;
  logic [ADDR_W-1:0] d_waddr;
  logic [DIST_W-1:0] d_wdata;
  logic [ADDR_W-1:0] d_ra_addr;
  logic [ADDR_W-1:0] d_rb_addr;
  logic [DIST_W-1:0] d_ra_data;
  logic [DIST_W-1:0] d_rb_data;
  logic              w_we;
  logic [NW-1:0]     w_waddr;
  logic [WEIGHT_W-1:0] w_wdata;
  logic [NW-1:0]     w_raddr;
  acc_ctl_t          acc_ctl;
  logic              acc_done;
  logic [TOTAL_W-1:0] best;
  logic              res_valid;
  logic              out_valid_q;
  logic [TOTAL_W-1:0] out_data_q;

  twcc_seq #(.MAX_NODES(MAX_NODES)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .weight_i    (s_axis_tdata[15:0]),
    .left_i      (s_axis_tdata[23:16]),
    .right_i     (s_axis_tdata[31:24]),
    .last_i      (s_axis_tlast),
    .out_busy_i  (out_valid_q),
    .res_valid_o (res_valid),
    .d_we_o      (d_we),
    .d_waddr_o   (d_waddr),
    .d_wdata_o   (d_wdata),
    .d_ra_addr_o (d_ra_addr),
    .d_rb_addr_o (d_rb_addr),
    .d_ra_data_i (d_ra_data),
    .d_rb_data_i (d_rb_data),
    .w_we_o      (w_we),
    .w_waddr_o   (w_waddr),
    .w_wdata_o   (w_wdata),
    .w_raddr_o   (w_raddr),
    .ctl_o       (acc_ctl),
    .acc_done_i  (acc_done)
  );

  twcc_dist_ram #(.ADDR_W(ADDR_W), .DATA_W(DIST_W)) u_dist (
    .clk_i     (clk_i),
    .we_i      (d_we),
    .waddr_i   (d_waddr),
    .wdata_i   (d_wdata),
    .ra_addr_i (d_ra_addr),
    .rb_addr_i (d_rb_addr),
    .ra_data_o (d_ra_data),
    .rb_data_o (d_rb_data)
  );

  twcc_cost_acc #(.MAX_NODES(MAX_NODES)) u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .w_we_i    (w_we),
    .w_waddr_i (w_waddr),
    .w_wdata_i (w_wdata),
    .w_raddr_i (w_raddr),
    .dist_i    (d_ra_data),
    .ctl_i     (acc_ctl),
    .best_o    (best),
    .done_o    (acc_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (res_valid) begin
        out_valid_q <= 1'b1;
        out_data_q  <= best;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/twcc_check.sv =====
// port-level checks for the top level, bound into it
module twcc_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // the last node of a tree starts the run, so loading stops
  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("request taken right after the last node");

  // matrix sweep follows reset
  a_reset_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("ready during the sweep after reset");

  // a result only appears while loading is stopped
  a_result_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !s_axis_tready)
    else $error("result appeared while nodes were loading");

endmodule

bind tree_weighted_center_cost_top twcc_check u_twcc_check (.*);
